// File: design/bspc_pkg.sv
package bspc_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int EntryW = 128;
  localparam int KeyW = 19;

  typedef enum logic [2:0] {
    REG_INTERIOR = 3'd0,
    REG_SOUTH    = 3'd1,
    REG_EAST     = 3'd2,
    REG_NORTH    = 3'd3,
    REG_WEST     = 3'd4
  } region_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT
  } state_t;

endpackage

// File: design/bspc_ram.sv
module bspc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/boundary_sort_point_cloud.sv
// Channel   | Direction | Payload
// in_       | input     | u_param v_param pos_x pos_y pos_z final_point
// out_      | output    | out_u out_v out_x out_y out_z region run_end
// A point, final or not, is stored only while fewer than MaxPoints are held.
// For a final point, each of the n results needs one full pass over the
// store through its single read port.
// The previous emitted key is held so that each pass picks the next point.
// Reset is synchronous and clears the count and bounds; the store is not cleared.
// A stalled result holds; no new point is taken until the cloud is emitted.
module boundary_sort_point_cloud (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_u_param,
  input  logic [15:0] in_v_param,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic        in_final_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_u,
  output logic [15:0] out_v,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [2:0]  out_region,
  output logic        out_run_end
);

  localparam int IW = bspc_pkg::IdxW;
  localparam int CW = bspc_pkg::CntW;
  localparam int KW = bspc_pkg::KeyW;

  bspc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] ulo_r, ulo_nxt, uhi_r, uhi_nxt, vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic [KW+IW-1:0] prev_r, prev_nxt;
  logic prev_ok_r, prev_ok_nxt;
  logic [KW+IW-1:0] best_r, best_nxt;
  logic best_ok_r, best_ok_nxt;

  logic in_acc, out_acc, store_ok;
  logic wr_en;
  logic [IW-1:0] rd_addr;
  logic [bspc_pkg::EntryW-1:0] wr_data, rd_data;
  logic [15:0] ru, rv;
  bspc_pkg::region_t rreg;
  logic [15:0] rkey;
  logic [KW+IW-1:0] rfull;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign store_ok = count_r < CW'(bspc_pkg::MaxPoints);
  assign wr_en = in_acc && store_ok;
  assign wr_data = {in_u_param, in_v_param, in_pos_x, in_pos_y, in_pos_z};

  bspc_ram #(.Width(bspc_pkg::EntryW), .Depth(bspc_pkg::MaxPoints)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count_r[IW-1:0]), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign ru = rd_data[127:112];
  assign rv = rd_data[111:96];

  always_comb begin
    if (ulo_r < ru && ru < uhi_r && vlo_r < rv && rv < vhi_r) begin
      rreg = bspc_pkg::REG_INTERIOR;
    end else if (ru == ulo_r && rv > vlo_r) begin
      rreg = bspc_pkg::REG_WEST;
    end else if (ru == uhi_r && rv < vhi_r) begin
      rreg = bspc_pkg::REG_EAST;
    end else if (rv == vlo_r && ru < uhi_r) begin
      rreg = bspc_pkg::REG_SOUTH;
    end else begin
      rreg = bspc_pkg::REG_NORTH;
    end
    case (rreg)
      bspc_pkg::REG_SOUTH: rkey = ru;
      bspc_pkg::REG_EAST:  rkey = rv;
      bspc_pkg::REG_NORTH: rkey = ~ru;
      bspc_pkg::REG_WEST:  rkey = ~rv;
      default:             rkey = 16'd0;
    endcase
  end

  // The scan index of the entry now on the read port is scan_r - 1.
  assign rfull = {rreg, rkey, IW'(scan_r - CW'(1))};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bspc_pkg::ST_LOAD:
        if (in_acc && in_final_point) begin
          state_nxt = bspc_pkg::ST_SCAN_RD;
        end
      bspc_pkg::ST_SCAN_RD:
        state_nxt = (count_r == '0) ? bspc_pkg::ST_LOAD : bspc_pkg::ST_SCAN;
      bspc_pkg::ST_SCAN:
        if (scan_r == count_r) begin
          state_nxt = bspc_pkg::ST_EMIT_RD;
        end
      bspc_pkg::ST_EMIT_RD:
        state_nxt = bspc_pkg::ST_EMIT_WAIT;
      bspc_pkg::ST_EMIT_WAIT:
        state_nxt = bspc_pkg::ST_EMIT;
      bspc_pkg::ST_EMIT:
        if (out_acc) begin
          state_nxt = (emitted_r + CW'(1) == count_r) ?
                      bspc_pkg::ST_LOAD : bspc_pkg::ST_SCAN_RD;
        end
      default: state_nxt = bspc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ulo_nxt = ulo_r;
    uhi_nxt = uhi_r;
    vlo_nxt = vlo_r;
    vhi_nxt = vhi_r;
    scan_nxt = scan_r;
    emitted_nxt = emitted_r;
    prev_nxt = prev_r;
    prev_ok_nxt = prev_ok_r;
    best_nxt = best_r;
    best_ok_nxt = best_ok_r;
    rd_addr = scan_r[IW-1:0];
    in_stall = state_r != bspc_pkg::ST_LOAD;
    out_valid = state_r == bspc_pkg::ST_EMIT;
    case (state_r)
      bspc_pkg::ST_LOAD: begin
        scan_nxt = '0;
        emitted_nxt = '0;
        prev_ok_nxt = 1'b0;
        if (wr_en) begin
          count_nxt = count_r + CW'(1);
          if (in_u_param < ulo_r) ulo_nxt = in_u_param;
          if (in_u_param > uhi_r) uhi_nxt = in_u_param;
          if (in_v_param < vlo_r) vlo_nxt = in_v_param;
          if (in_v_param > vhi_r) vhi_nxt = in_v_param;
        end
      end
      bspc_pkg::ST_SCAN_RD: begin
        rd_addr = '0;
        scan_nxt = CW'(1);
        best_ok_nxt = 1'b0;
        if (count_r == '0) begin
          ulo_nxt = '1;
          uhi_nxt = '0;
          vlo_nxt = '1;
          vhi_nxt = '0;
        end
      end
      bspc_pkg::ST_SCAN: begin
        rd_addr = scan_r[IW-1:0];
        if ((!prev_ok_r || rfull > prev_r) && (!best_ok_r || rfull < best_r)) begin
          best_nxt = rfull;
          best_ok_nxt = 1'b1;
        end
        scan_nxt = scan_r + CW'(1);
      end
      bspc_pkg::ST_EMIT_RD: begin
        rd_addr = best_r[IW-1:0];
        scan_nxt = {{(CW-IW){1'b0}}, best_r[IW-1:0]} + CW'(1);
      end
      bspc_pkg::ST_EMIT_WAIT: begin
        rd_addr = best_r[IW-1:0];
      end
      bspc_pkg::ST_EMIT: begin
        rd_addr = best_r[IW-1:0];
        if (out_acc) begin
          prev_nxt = best_r;
          prev_ok_nxt = 1'b1;
          emitted_nxt = emitted_r + CW'(1);
          if (emitted_r + CW'(1) == count_r) begin
            count_nxt = '0;
            ulo_nxt = '1;
            uhi_nxt = '0;
            vlo_nxt = '1;
            vhi_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_u = ru;
  assign out_v = rv;
  assign out_x = rd_data[95:64];
  assign out_y = rd_data[63:32];
  assign out_z = rd_data[31:0];
  assign out_region = rreg;
  assign out_run_end = emitted_r + CW'(1) == count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bspc_pkg::ST_LOAD;
      count_r <= '0;
      ulo_r <= '1;
      uhi_r <= '0;
      vlo_r <= '1;
      vhi_r <= '0;
      prev_ok_r <= 1'b0;
      best_ok_r <= 1'b0;
      scan_r <= '0;
      emitted_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ulo_r <= ulo_nxt;
      uhi_r <= uhi_nxt;
      vlo_r <= vlo_nxt;
      vhi_r <= vhi_nxt;
      prev_ok_r <= prev_ok_nxt;
      best_ok_r <= best_ok_nxt;
      scan_r <= scan_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    best_r <= best_nxt;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(bspc_pkg::MaxPoints)) else $error("point count overflow");
  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_ok_r) else $error("emit without a selected point");
  a_emit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> emitted_r < count_r) else $error("too many results");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while emitting");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_ok_r |-> best_r > prev_r) else $error("output out of order");
`endif

endmodule
